/* design/lidar_frame_parser_assert.svh */
// assertion macros shared by the lidar frame parser modules
// expects signals named clock and reset in the including module
`ifndef LIDAR_FRAME_PARSER_ASSERT_SVH
`define LIDAR_FRAME_PARSER_ASSERT_SVH

// condition holds at every edge outside reset
`define LFP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lidar frame parser: invariant violated");

// consequent holds in the same cycle as the antecedent
`define LFP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lidar frame parser: implication violated");

// consequent holds in the cycle after the antecedent
`define LFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lidar frame parser: next-cycle check violated");

`endif

/* design/lfp_pkg.sv */
// shared types, constants and helpers for the lidar frame parser
// no dependencies; imported by every module of the block
package lfp_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int COUNT_OUT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int PAYLOAD_BYTES = 6;

   localparam logic [7:0] HDR_BYTE = 8'h59;

   localparam logic [3:0] POS_HUNT = 4'd0;
   localparam logic [3:0] POS_HEADER = 4'd1;
   localparam logic [3:0] POS_FIRST_DATA = 4'd2;
   localparam logic [3:0] POS_LAST_DATA = 4'd7;
   localparam logic [3:0] POS_CHECKSUM = 4'd8;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_HDR_ERR = 2'd1;
   localparam logic [1:0] OP_CSUM_ERR = 2'd2;
   localparam logic [1:0] OP_GOOD = 2'd3;

   localparam logic signed [16:0] TEMP_OFFSET = 17'sd2048;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [COUNT_OUT_WIDTH-1:0] count_out_type;
   typedef logic [QPTR_WIDTH-1:0] qptr_type;
   typedef logic [QCOUNT_WIDTH-1:0] qcount_type;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] distance;
      logic [15:0] strength;
      logic signed [15:0] temperature;
   } entry_type;

   function automatic logic signed [16:0] temp_to_eighths(input logic signed [15:0] temp);
      logic signed [16:0] wide;
      wide = 17'(temp);
      return wide - TEMP_OFFSET;
   endfunction

endpackage

/* design/lfp_channels.sv */
// valid/ready channel interfaces for the lidar frame parser ports
// no dependencies
interface lfp_req_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_rsp_if;
   logic valid;
   logic ready;
   logic frame_done;
   logic [15:0] range_cm;
   logic [15:0] signal_strength;
   logic signed [15:0] temp_raw;
   logic signed [16:0] temp_eighths_c;
   logic [31:0] good_frame_count;
   logic [31:0] checksum_fail_count;
   logic [31:0] header_fail_count;
   logic [31:0] byte_count;

   modport source (output valid, output frame_done, output range_cm,
                   output signal_strength, output temp_raw, output temp_eighths_c,
                   output good_frame_count, output checksum_fail_count,
                   output header_fail_count, output byte_count, input ready);
   modport sink (input valid, input frame_done, input range_cm,
                 input signal_strength, input temp_raw, input temp_eighths_c,
                 input good_frame_count, input checksum_fail_count,
                 input header_fail_count, input byte_count, output ready);
endinterface

/* design/lidar_frame_parser.sv */
// Byte-serial parser for 9-byte lidar frames: two 0x59 header bytes, six payload
// bytes (distance, strength, temperature, little endian) and an 8-bit sum check.
// Every accepted byte yields exactly one result transfer carrying the held values and
// the wrapping counters as they stand after that byte; frame_done marks the byte that
// closed a good frame. The block takes one byte per clock while the result side
// accepts one per clock. A byte is classified and written into the two-entry queue when
// it is taken, then moves into the output register of the back end once that register
// is free, and its result is offered from there. The queue and the output register hold
// up to three results; when the result side stalls, the input stalls once the queue is
// full, in a steady stream the cycle after.
// Depends on lfp_pkg, lfp_channels, lfp_front, lfp_queue and lfp_back.
module lidar_frame_parser import lfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lfp_req_if.sink   req_link,
   lfp_rsp_if.source rsp_link
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   lfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_link   (req_link),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   lfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_link  (rsp_link)
   );

endmodule

/* design/lfp_front.sv */
// front end: frame position tracking, running checksum and payload capture
// depends on lfp_pkg, lfp_channels and the assertion macro header
`include "lidar_frame_parser_assert.svh"

module lfp_front import lfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lfp_req_if.sink   req_link,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_entry
);

   logic [3:0] frame_pos_ff, frame_pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] payload_ff [PAYLOAD_BYTES];
   logic [7:0] rx;
   logic       take;
   logic       shift_en;
   logic [1:0] op;

   assign rx = req_link.rx_byte;
   assign req_link.ready = push_ready;
   assign push_valid = req_link.valid;
   assign take = req_link.valid && push_ready;

   always_comb begin
      frame_pos_in = frame_pos_ff;
      sum_in = sum_ff;
      shift_en = 1'b0;
      op = OP_NONE;
      unique case (frame_pos_ff) inside
         POS_HEADER: begin
            if (rx == HDR_BYTE) begin
               frame_pos_in = POS_FIRST_DATA;
               sum_in = sum_ff + rx;
            end else begin
               frame_pos_in = POS_HUNT;
               op = OP_HDR_ERR;
            end
         end
         [POS_FIRST_DATA:POS_LAST_DATA]: begin
            frame_pos_in = frame_pos_ff + 4'd1;
            sum_in = sum_ff + rx;
            shift_en = 1'b1;
         end
         POS_CHECKSUM: begin
            if (sum_ff == rx) begin
               frame_pos_in = POS_HUNT;
               op = OP_GOOD;
            end else begin
               op = OP_CSUM_ERR;
               if (rx == HDR_BYTE) begin
                  frame_pos_in = POS_HEADER;
                  sum_in = rx;
               end else begin
                  frame_pos_in = POS_HUNT;
               end
            end
         end
         default: begin
            if (rx == HDR_BYTE) begin
               frame_pos_in = POS_HEADER;
               sum_in = rx;
            end
         end
      endcase
   end

   always_comb begin
      push_entry.op = op;
      push_entry.distance = {payload_ff[1], payload_ff[0]};
      push_entry.strength = {payload_ff[3], payload_ff[2]};
      push_entry.temperature = {payload_ff[5], payload_ff[4]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= POS_HUNT;
      end else if (take) begin
         frame_pos_ff <= frame_pos_in;
      end
   end

   // shift line: oldest payload byte ends at index 0
   always_ff @(posedge clock) begin
      if (take) begin
         sum_ff <= sum_in;
      end
      if (take && shift_en) begin
         for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
            payload_ff[i] <= payload_ff[i+1];
         end
         payload_ff[PAYLOAD_BYTES-1] <= rx;
      end
   end

   `LFP_ASSERT_ALWAYS(a_pos_range, frame_pos_ff <= POS_CHECKSUM)
   `LFP_ASSERT_NEXT(a_header_err_restarts, take && op == OP_HDR_ERR, frame_pos_ff == POS_HUNT)

endmodule

/* design/lfp_queue.sv */
// short fifo of classified bytes between the front and back ends
// depends on lfp_pkg and the assertion macro header
`include "lidar_frame_parser_assert.svh"

module lfp_queue import lfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   entry_type  slot_ff [QUEUE_DEPTH];
   qptr_type   wr_ptr_ff, wr_ptr_in;
   qptr_type   rd_ptr_ff, rd_ptr_in;
   qcount_type count_ff, count_in;
   logic       push;
   logic       pop;

   function automatic qptr_type next_ptr(input qptr_type ptr);
      if (ptr == qptr_type'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + qptr_type'(1);
   endfunction

   assign in_ready = count_ff != qcount_type'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10: count_in = count_ff + qcount_type'(1);
         2'b01: count_in = count_ff - qcount_type'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   `LFP_ASSERT_ALWAYS(a_count_bound, count_ff <= qcount_type'(QUEUE_DEPTH))
   `LFP_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + qcount_type'(1))

endmodule

/* design/lfp_back.sv */
// back end: held measurement words, wrapping counters and result register
// depends on lfp_pkg, lfp_channels and the assertion macro header
`include "lidar_frame_parser_assert.svh"

module lfp_back import lfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_entry,
   lfp_rsp_if.source rsp_link
);

   logic                valid_ff, valid_in;
   logic                done_ff;
   logic [15:0]         dist_ff;
   logic [15:0]         str_ff;
   logic signed [15:0]  temp_ff;
   logic signed [16:0]  eighths_ff;
   count_type           cnt_good_ff;
   count_type           cnt_csum_ff;
   count_type           cnt_hdr_ff;
   count_type           cnt_byte_ff;
   logic                pop;

   assign pop_ready = !valid_ff || rsp_link.ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_link.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff <= 1'b0;
         dist_ff <= '0;
         str_ff <= '0;
         temp_ff <= '0;
         eighths_ff <= -TEMP_OFFSET;
         cnt_good_ff <= '0;
         cnt_csum_ff <= '0;
         cnt_hdr_ff <= '0;
         cnt_byte_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            cnt_byte_ff <= cnt_byte_ff + count_type'(1);
            done_ff <= pop_entry.op == OP_GOOD;
            unique case (pop_entry.op)
               OP_HDR_ERR: cnt_hdr_ff <= cnt_hdr_ff + count_type'(1);
               OP_CSUM_ERR: cnt_csum_ff <= cnt_csum_ff + count_type'(1);
               OP_GOOD: begin
                  dist_ff <= pop_entry.distance;
                  str_ff <= pop_entry.strength;
                  temp_ff <= pop_entry.temperature;
                  eighths_ff <= temp_to_eighths(pop_entry.temperature);
                  cnt_good_ff <= cnt_good_ff + count_type'(1);
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_link.valid = valid_ff;
   assign rsp_link.frame_done = done_ff;
   assign rsp_link.range_cm = dist_ff;
   assign rsp_link.signal_strength = str_ff;
   assign rsp_link.temp_raw = temp_ff;
   assign rsp_link.temp_eighths_c = eighths_ff;
   assign rsp_link.good_frame_count = count_out_type'(cnt_good_ff);
   assign rsp_link.checksum_fail_count = count_out_type'(cnt_csum_ff);
   assign rsp_link.header_fail_count = count_out_type'(cnt_hdr_ff);
   assign rsp_link.byte_count = count_out_type'(cnt_byte_ff);

   `LFP_ASSERT_NEXT(a_good_sets_done, pop && pop_entry.op == OP_GOOD, done_ff && valid_ff)
   `LFP_ASSERT_NEXT(a_byte_count_step, pop, cnt_byte_ff == $past(cnt_byte_ff) + count_type'(1))

endmodule
